// File: rtl/awra_pkg.sv
package awra_pkg;

  localparam int unsigned DepthDefault = 64;

  localparam int unsigned RssiW   = 8;
  localparam int unsigned StampW  = 32;
  localparam int unsigned WindowW = 16;
  localparam int unsigned UsedW   = 7;
  localparam int unsigned ProdW   = RssiW + WindowW + 1;

  localparam logic [WindowW-1:0] WindowReset = 16'd5000;

  localparam logic CmdStore   = 1'b0;
  localparam logic CmdCompute = 1'b1;

  typedef enum logic [1:0] {
    StIdle,
    StWalk,
    StDrain,
    StDiv
  } awra_state_e;

endpackage

// File: rtl/awra_mem.sv
module awra_mem
  import awra_pkg::*;
#(
  parameter int unsigned DEPTH = DepthDefault,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [AW-1:0]            waddr_i,
  input  logic signed [RssiW-1:0]  sample_i,
  input  logic [StampW-1:0]        stamp_i,
  input  logic [AW-1:0]            raddr_i,
  output logic signed [RssiW-1:0]  sample_o,
  output logic [StampW-1:0]        stamp_o
);

  logic signed [RssiW-1:0] sample_mem [DEPTH];
  logic [StampW-1:0]       stamp_mem  [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      sample_mem[waddr_i] <= sample_i;
      stamp_mem[waddr_i]  <= stamp_i;
    end
    sample_o <= sample_mem[raddr_i];
    stamp_o  <= stamp_mem[raddr_i];
  end

endmodule

// File: rtl/awra_div.sv
module awra_div
  import awra_pkg::*;
#(
  parameter int unsigned SUM_W = 32,
  parameter int unsigned DEN_W = 24,
  localparam int unsigned CW = (SUM_W > DEN_W + RssiW - 1) ? SUM_W : DEN_W + RssiW - 1
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic signed [SUM_W-1:0]  dividend_i,
  input  logic [DEN_W-1:0]         divisor_i,
  output logic                     done_o,
  output logic signed [RssiW-1:0]  quotient_o
);

  logic                    run_q, run_d;
  logic                    done_q, done_d;
  logic [2:0]              step_q;
  logic                    neg_q;
  logic                    zero_q;
  logic [CW-1:0]           rem_q;
  logic [CW-1:0]           dsh_q;
  logic [RssiW-2:0]        quo_q;
  logic signed [RssiW-1:0] quotient_q;

  logic [SUM_W-1:0]        mag;
  logic                    ge;
  logic [RssiW-1:0]        q_full;
  logic [RssiW-1:0]        q_final;
  logic                    last;

  // The weighted mean lies between the smallest and largest sample, so the
  // quotient magnitude never exceeds 128 and eight restoring steps suffice.
  assign mag    = dividend_i[SUM_W-1] ? (SUM_W)'(-dividend_i) : dividend_i;
  assign ge     = (rem_q >= dsh_q);
  assign q_full = {quo_q, ge};
  assign last   = run_q && (step_q == 3'd0);

  always_comb begin
    if (zero_q) begin
      q_final = '0;
    end else if (neg_q) begin
      q_final = (q_full > 8'd128) ? 8'h80 : 8'(8'd0 - q_full);
    end else begin
      q_final = (q_full > 8'd127) ? 8'h7f : q_full;
    end
  end

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      run_d = 1'b1;
    end else if (last) begin
      run_d  = 1'b0;
      done_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q  <= dividend_i[SUM_W-1];
      zero_q <= (divisor_i == '0);
      rem_q  <= CW'(mag);
      dsh_q  <= CW'(divisor_i) << (RssiW - 1);
      quo_q  <= '0;
      step_q <= 3'd7;
    end else if (run_q) begin
      if (ge) begin
        rem_q <= rem_q - dsh_q;
      end
      quo_q  <= q_full[RssiW-2:0];
      dsh_q  <= dsh_q >> 1;
      step_q <= step_q - 3'd1;
    end
    if (last) begin
      quotient_q <= q_final;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quotient_q;

endmodule

// File: rtl/age_weighted_rssi_average.sv
// Age-weighted RSSI average.
// Command channel: a word is taken on a rising edge with start high and busy
// low. command_i low stores rssi_i stamped with now_ms_i into the next ring
// slot (the oldest entry is overwritten once DEPTH samples are held);
// busy never rises and no result follows.
// command_i high computes the average over the stored samples: each sample
// whose age (now_ms_i minus its stamp, modulo 2^32) is at most the window
// is weighted by window minus age. busy stays high until the result appears.
// Result channel: result_valid_o is high for exactly one cycle with
// average_o and samples_used_o; the receiver cannot stall it. average_o
// keeps the last average between results.
// Course of a compute: the single memory read port walks the N stored
// samples one entry a cycle into a three-stage weight/multiply/accumulate
// pipeline; once it drains, an eight-step restoring divider that shares one
// compare-subtract unit forms the average. busy drops in the result cycle,
// so the next command can be taken from the result cycle on, not before.
// Configuration: window_we_i writes window_wdata_i (default 5000 ms).
// Reset clears the ring pointers, sample count and last average; the sample
// memory itself is not cleared and unwritten entries are never read.
module age_weighted_rssi_average
  import awra_pkg::*;
#(
  parameter int unsigned DEPTH = DepthDefault
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic                     command_i,
  input  logic signed [RssiW-1:0]  rssi_i,
  input  logic [StampW-1:0]        now_ms_i,
  input  logic                     window_we_i,
  input  logic [WindowW-1:0]       window_wdata_i,
  output logic                     result_valid_o,
  output logic signed [RssiW-1:0]  average_o,
  output logic [UsedW-1:0]         samples_used_o
);

  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CntW  = AW + 1;
  localparam int unsigned SumW  = ProdW + AW + 1;
  localparam int unsigned DenW  = WindowW + AW + 1;

  awra_state_e state_q, state_d;

  logic [WindowW-1:0]       window_q;
  logic [AW-1:0]            wslot_q, wslot_d;
  logic [CntW-1:0]          cnt_q, cnt_d;
  logic [CntW-1:0]          idx_q, idx_d;
  logic [StampW-1:0]        now_q;
  logic signed [RssiW-1:0]  last_avg_q;
  logic                     result_valid_q;
  logic [UsedW-1:0]         used_out_q;

  logic                     accept, store_we, compute_go;
  logic                     issue, div_start, pipe_empty, walk_last;

  logic signed [RssiW-1:0]  rd_sample;
  logic [StampW-1:0]        rd_stamp;

  logic                     p1_q, p2_q, p3_q;
  logic                     v2_q, v3_q;
  logic [StampW-1:0]        age;
  logic                     in_win;
  logic signed [RssiW-1:0]  rssi2_q;
  logic [WindowW-1:0]       weight2_q, weight3_q;
  logic signed [ProdW-1:0]  prod_q;

  logic signed [SumW-1:0]   wsum_q;
  logic [DenW-1:0]          den_q;
  logic [CntW-1:0]          used_q;
  logic [CntW+UsedW-1:0]    used_ext;

  logic                     div_done;
  logic signed [RssiW-1:0]  div_quot;

  assign accept     = start && !busy;
  assign store_we   = accept && (command_i == CmdStore);
  assign compute_go = accept && (command_i == CmdCompute);
  assign pipe_empty = !p1_q && !p2_q && !p3_q;
  assign walk_last  = !((idx_q + CntW'(1)) < cnt_q);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:  if (compute_go) state_d = StWalk;
      StWalk:  if (walk_last) state_d = StDrain;
      StDrain: if (pipe_empty) state_d = StDiv;
      StDiv:   if (div_done) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    busy      = 1'b1;
    issue     = 1'b0;
    div_start = 1'b0;
    unique case (state_q)
      StIdle:  busy = 1'b0;
      StWalk:  issue = (idx_q < cnt_q);
      StDrain: div_start = pipe_empty;
      StDiv:   ;
      default: busy = 1'b0;
    endcase
  end

  always_comb begin
    wslot_d = wslot_q;
    cnt_d   = cnt_q;
    if (store_we) begin
      wslot_d = (wslot_q == AW'(DEPTH - 1)) ? '0 : wslot_q + AW'(1);
      if (cnt_q != CntW'(DEPTH)) begin
        cnt_d = cnt_q + CntW'(1);
      end
    end
  end

  always_comb begin
    idx_d = idx_q;
    if (compute_go) begin
      idx_d = '0;
    end else if (issue) begin
      idx_d = idx_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= StIdle;
      window_q       <= WindowReset;
      wslot_q        <= '0;
      cnt_q          <= '0;
      idx_q          <= '0;
      last_avg_q     <= '0;
      result_valid_q <= 1'b0;
      p1_q           <= 1'b0;
      p2_q           <= 1'b0;
      p3_q           <= 1'b0;
      v2_q           <= 1'b0;
      v3_q           <= 1'b0;
    end else begin
      state_q        <= state_d;
      wslot_q        <= wslot_d;
      cnt_q          <= cnt_d;
      idx_q          <= idx_d;
      result_valid_q <= div_done;
      p1_q           <= issue;
      p2_q           <= p1_q;
      p3_q           <= p2_q;
      v2_q           <= p1_q && in_win;
      v3_q           <= v2_q;
      if (window_we_i) begin
        window_q <= window_wdata_i;
      end
      if (div_done) begin
        last_avg_q <= div_quot;
      end
    end
  end

  awra_mem #(
    .DEPTH (DEPTH)
  ) u_mem (
    .clk_i    (clk_i),
    .we_i     (store_we),
    .waddr_i  (wslot_q),
    .sample_i (rssi_i),
    .stamp_i  (now_ms_i),
    .raddr_i  (idx_q[AW-1:0]),
    .sample_o (rd_sample),
    .stamp_o  (rd_stamp)
  );

  // Stage one: age and window test. A stamp later than now wraps to a huge
  // age and falls outside the window.
  assign age    = now_q - rd_stamp;
  assign in_win = (age <= StampW'(window_q));

  always_ff @(posedge clk_i) begin
    if (compute_go) begin
      now_q  <= now_ms_i;
      wsum_q <= '0;
      den_q  <= '0;
      used_q <= '0;
    end else if (v3_q) begin
      wsum_q <= wsum_q + SumW'(prod_q);
      den_q  <= den_q + DenW'(weight3_q);
      used_q <= used_q + CntW'(1);
    end
    rssi2_q   <= rd_sample;
    weight2_q <= window_q - age[WindowW-1:0];
    prod_q    <= ProdW'(rssi2_q) * ProdW'($signed({1'b0, weight2_q}));
    weight3_q <= weight2_q;
    if (div_done) begin
      used_out_q <= (used_ext > (CntW + UsedW)'(127)) ? UsedW'(127) : used_ext[UsedW-1:0];
    end
  end

  assign used_ext = (CntW + UsedW)'(used_q);

  awra_div #(
    .SUM_W (SumW),
    .DEN_W (DenW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (wsum_q),
    .divisor_i  (den_q),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  assign result_valid_o = result_valid_q;
  assign average_o      = last_avg_q;
  assign samples_used_o = used_out_q;

endmodule

// File: rtl/awra_chk.sv
module awra_chk
  import awra_pkg::*;
(
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    start,
  input logic                    busy,
  input logic                    command_i,
  input logic                    result_valid_o,
  input logic signed [RssiW-1:0] average_o
);

  // A compute word always raises busy in the cycle after it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && command_i == CmdCompute) |=> busy)
    else $error("compute word did not raise busy");

  // A store word finishes in the cycle it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && command_i == CmdStore) |=> !busy)
    else $error("store word raised busy");

  // Each result word follows a busy period and lasts one cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy))
    else $error("result word without a preceding compute");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result word repeated");

  // The average only changes when a result word is shown.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !result_valid_o |-> $stable(average_o) || $past(!rst_ni))
    else $error("average changed without a result word");

endmodule

bind age_weighted_rssi_average awra_chk u_awra_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .command_i      (command_i),
  .result_valid_o (result_valid_o),
  .average_o      (average_o)
);

// File: test/awra_average_watch.sv
module awra_average_watch
  import awra_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic                    busy_i,
  input  logic                    command_i,
  input  logic signed [RssiW-1:0] rssi_i,
  input  logic [StampW-1:0]       now_ms_i,
  input  logic                    window_we_i,
  input  logic [WindowW-1:0]      window_wdata_i,
  input  logic                    result_valid_i,
  input  logic signed [RssiW-1:0] average_i,
  input  logic [UsedW-1:0]        samples_used_i,
  output int                      mismatches_o,
  output int                      outstanding_o,
  output int                      stores_o,
  output int                      averages_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [RssiW-1:0] average;
    logic [UsedW-1:0]        used;
  } rssi_avg_t;

  logic signed [RssiW-1:0] ring_rssi  [DepthDefault];
  logic [StampW-1:0]       ring_stamp [DepthDefault];
  int unsigned             ring_fill;
  int unsigned             ring_slot;
  logic [WindowW-1:0]      window_ms;
  rssi_avg_t               pending_averages_q [$];

  // Weights every held sample whose age is within the window by window minus
  // age; ages wrap at 32 bits, so a stamp ahead of now looks very old and drops out.
  function automatic rssi_avg_t weigh_ring(input logic [StampW-1:0] now_ms);
    rssi_avg_t        r;
    longint           wsum;
    longint           wtotal;
    longint           quot;
    longint           weight;
    logic [StampW-1:0] age;
    int unsigned      used;
    wsum = 0;
    wtotal = 0;
    quot = 0;
    used = 0;
    for (int i = 0; i < ring_fill; i++) begin
      age = now_ms - ring_stamp[i];
      if (age <= StampW'(window_ms)) begin
        weight = longint'(window_ms) - longint'(age);
        wsum += longint'(ring_rssi[i]) * weight;
        wtotal += weight;
        used++;
      end
    end
    if (wtotal != 0) quot = wsum / wtotal;
    if (quot > 127) quot = 127;
    if (quot < -128) quot = -128;
    r.average = quot[RssiW-1:0];
    r.used = (used > 127) ? UsedW'(127) : UsedW'(used);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    rssi_avg_t want;
    if (!rst_ni) begin
      ring_fill = 0;
      ring_slot = 0;
      window_ms = WindowReset;
      pending_averages_q.delete();
      mismatches_o = 0;
      outstanding_o = 0;
      stores_o = 0;
      averages_o = 0;
    end else begin
      // A result word is matched before a new command is taken at this edge.
      if (result_valid_i) begin
        if (pending_averages_q.size() == 0) begin
          mismatches_o++;
          $display("%0t: unexpected result word, average %0d samples_used %0d",
                   $time, average_i, samples_used_i);
        end else begin
          want = pending_averages_q.pop_front();
          averages_o++;
          if (average_i !== want.average) begin
            mismatches_o++;
            $display("%0t: average expected %0d actual %0d",
                     $time, want.average, average_i);
          end
          if (samples_used_i !== want.used) begin
            mismatches_o++;
            $display("%0t: samples_used expected %0d actual %0d",
                     $time, want.used, samples_used_i);
          end
        end
      end
      if (window_we_i) window_ms = window_wdata_i;
      if (start_i && !busy_i) begin
        if (command_i == CmdStore) begin
          ring_rssi[ring_slot] = rssi_i;
          ring_stamp[ring_slot] = now_ms_i;
          ring_slot = (ring_slot + 1) % DepthDefault;
          if (ring_fill < DepthDefault) ring_fill++;
          stores_o++;
        end else begin
          pending_averages_q = {pending_averages_q, weigh_ring(now_ms_i)};
        end
      end
      outstanding_o = pending_averages_q.size();
    end
  end

endmodule

// File: test/age_weighted_rssi_average_tb.sv
module age_weighted_rssi_average_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import awra_pkg::*;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    start;
  logic                    busy;
  logic                    command_i;
  logic signed [RssiW-1:0] rssi_i;
  logic [StampW-1:0]       now_ms_i;
  logic                    window_we_i;
  logic [WindowW-1:0]      window_wdata_i;
  logic                    result_valid_o;
  logic signed [RssiW-1:0] average_o;
  logic [UsedW-1:0]        samples_used_o;

  int mismatches;
  int outstanding;
  int stores_seen;
  int averages_seen;
  int window_writes;

  age_weighted_rssi_average dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .command_i      (command_i),
    .rssi_i         (rssi_i),
    .now_ms_i       (now_ms_i),
    .window_we_i    (window_we_i),
    .window_wdata_i (window_wdata_i),
    .result_valid_o (result_valid_o),
    .average_o      (average_o),
    .samples_used_o (samples_used_o)
  );

  awra_average_watch average_watch (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_i         (busy),
    .command_i      (command_i),
    .rssi_i         (rssi_i),
    .now_ms_i       (now_ms_i),
    .window_we_i    (window_we_i),
    .window_wdata_i (window_wdata_i),
    .result_valid_i (result_valid_o),
    .average_i      (average_o),
    .samples_used_i (samples_used_o),
    .mismatches_o   (mismatches),
    .outstanding_o  (outstanding),
    .stores_o       (stores_seen),
    .averages_o     (averages_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("age_weighted_rssi_average verification failed");
    $finish;
  end

  // Presents one command word and returns at the falling edge after it is taken.
  // Start stays high so that a following word needs no second assignment.
  task automatic issue(input logic cmd, input logic signed [RssiW-1:0] rssi,
                       input logic [StampW-1:0] now_ms);
    start <= 1'b1;
    command_i <= cmd;
    rssi_i <= rssi;
    now_ms_i <= now_ms;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
  endtask

  task automatic pause_sender(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(negedge clk_i);
  endtask

  task automatic random_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return;
    if (roll < 92) pause_sender($urandom_range(1, 3));
    else pause_sender($urandom_range(10, 40));
  endtask

  // Holds off until every average is back, then lets the block go quiet.
  task automatic settle();
    int guard;
    guard = 0;
    pause_sender(1);
    while (outstanding != 0 && guard < 2000) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (100) @(negedge clk_i);
  endtask

  task automatic set_window(input logic [WindowW-1:0] w);
    settle();
    window_we_i <= 1'b1;
    window_wdata_i <= w;
    @(negedge clk_i);
    window_we_i <= 1'b0;
    window_writes++;
  endtask

  // Mostly a sample stream on an advancing clock with averages taken around
  // it, plus some commands at arbitrary times.
  task automatic random_phase(input logic [WindowW-1:0] w, input int items);
    logic [StampW-1:0] clock_ms;
    logic [StampW-1:0] now_ms;
    logic [StampW-1:0] span;
    int                pick;
    bit                calm;
    span = StampW'(w);
    calm = 1'b0;
    if ($urandom_range(0, 3) == 0) clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 40 * span);
    else clock_ms = $urandom();
    for (int n = 0; n < items; n++) begin
      if (n % 48 == 0) calm = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        issue(CmdStore, RssiW'($urandom()), clock_ms);
        if ($urandom_range(0, 19) == 0) clock_ms += $urandom_range(0, 2 * span + 2);
        else clock_ms += $urandom_range(0, span / 16 + 1);
      end else if (pick < 85) begin
        if ($urandom_range(0, 4) == 0) now_ms = clock_ms - $urandom_range(0, span / 4 + 1);
        else now_ms = clock_ms + $urandom_range(0, span + span / 4 + 1);
        issue(CmdCompute, RssiW'($urandom()), now_ms);
      end else if (pick < 95) begin
        issue(CmdCompute, RssiW'($urandom()), $urandom());
      end else begin
        issue(CmdStore, RssiW'($urandom()), $urandom());
      end
      if (!calm) random_gap();
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    start = 1'b0;
    command_i = CmdStore;
    rssi_i = '0;
    now_ms_i = '0;
    window_we_i = 1'b0;
    window_wdata_i = '0;
    window_writes = 0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset window of 5000 ms.
    issue(CmdCompute, 8'sh00, 32'd0);
    issue(CmdStore, 8'sh80, 32'd1000);
    issue(CmdStore, 8'sh7F, 32'd1000);
    // Equal weights on -128 and 127 give -0.5, which truncates to zero.
    issue(CmdCompute, 8'sh00, 32'd1000);
    issue(CmdStore, 8'shFF, 32'd3000);
    // Age equal to the window is counted but carries no weight.
    issue(CmdCompute, 8'sh00, 32'd6000);
    issue(CmdCompute, 8'sh00, 32'd6001);
    issue(CmdCompute, 8'sh00, 32'd999);
    set_window(16'd0);
    issue(CmdCompute, 8'sh00, 32'd3000);
    set_window(16'hFFFF);
    issue(CmdStore, 8'sh64, 32'hFFFF_FFF0);
    issue(CmdCompute, 8'sh00, 32'h0000_0010);
    set_window(16'd1);
    issue(CmdStore, 8'sh05, 32'd20);
    issue(CmdCompute, 8'sh00, 32'd21);
    issue(CmdStore, 8'shF9, 32'd21);
    issue(CmdCompute, 8'sh00, 32'd21);

    set_window(16'hFFFF);
    random_phase(16'hFFFF, 377);
    set_window(16'd1);
    random_phase(16'd1, 377);
    set_window(WindowW'($urandom_range(2, 200)));
    random_phase(window_wdata_i, 377);
    set_window(WindowW'($urandom_range(1, 65535)));
    random_phase(window_wdata_i, 377);
    set_window(WindowReset);
    random_phase(WindowReset, 377);
    settle();

    $display("Checked %0d averages against %0d stored samples over %0d window writes,",
             averages_seen, stores_seen, window_writes);
    $display("covering windows of 0, 1 and 65535 ms, wrapped stamps and a full ring.");
    if (mismatches == 0 && outstanding == 0) begin
      $display("age_weighted_rssi_average verification clean");
    end else begin
      if (outstanding != 0) $display("%0t: %0d averages never arrived", $time, outstanding);
      $display("age_weighted_rssi_average verification failed");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/awra_pkg.sv
rtl/awra_mem.sv
rtl/awra_div.sv
rtl/age_weighted_rssi_average.sv
rtl/awra_chk.sv
test/awra_average_watch.sv
test/age_weighted_rssi_average_tb.sv
